FILE: hdl/uff_pkg.sv
// ----------------------------------------------------------------------------
// uff_pkg
// Types, widths, kind codes and the digit-to-ASCII helper for the field
// formatter.
// ----------------------------------------------------------------------------
package uff_pkg;

	localparam int OP_W    = 2;
	localparam int VALUE_W = 16;
	localparam int FW_W    = 4;
	localparam int CHAR_W  = 8;
	localparam int BCD_W   = 20;
	localparam int DIG_W   = 24;
	localparam int NDIG_W  = 3;

	localparam logic [FW_W-1:0] MAX_CHARS = 4'd9;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_DEC  = 2'd0;
	localparam op_t OP_OCT  = 2'd1;
	localparam op_t OP_HEX  = 2'd2;
	localparam op_t OP_CHAR = 2'd3;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h57;

	function automatic logic [CHAR_W-1:0] ascii_digit(input logic [3:0] d);
		logic [CHAR_W-1:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {4'h0, d};
		end else begin
			r = CH_ALPHA + {4'h0, d};
		end
		return r;
	endfunction

endpackage

FILE: hdl/uff_in_if.sv
// ----------------------------------------------------------------------------
// uff_in_if
// Request channel: one word carries a value and its formatting controls.
// ----------------------------------------------------------------------------
interface uff_in_if;
	logic                        valid;
	logic                        ready;
	logic [uff_pkg::OP_W-1:0]    op;
	logic [uff_pkg::VALUE_W-1:0] value;
	logic [uff_pkg::FW_W-1:0]    field_width;
	logic                        zero_pad;

	modport source (output valid, op, value, field_width, zero_pad, input ready);
	modport sink   (input valid, op, value, field_width, zero_pad, output ready);
endinterface

FILE: hdl/uff_out_if.sv
// ----------------------------------------------------------------------------
// uff_out_if
// Character channel: one word carries one ASCII character and a last flag.
// ----------------------------------------------------------------------------
interface uff_out_if;
	logic                       valid;
	logic                       ready;
	logic [uff_pkg::CHAR_W-1:0] out_char;
	logic                       last;

	modport source (output valid, out_char, last, input ready);
	modport sink   (input valid, out_char, last, output ready);
endinterface

FILE: hdl/uff_bcd.sv
// ----------------------------------------------------------------------------
// uff_bcd
// Bit-serial binary to BCD converter using shift and add-three, one input
// bit per cycle.
// ----------------------------------------------------------------------------
module uff_bcd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [uff_pkg::VALUE_W-1:0] value,
	output logic                        done,
	output logic [uff_pkg::BCD_W-1:0]   bcd
);
	import uff_pkg::*;

	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;
	logic [VALUE_W-1:0] bin_q;
	logic [3:0]         cnt_q;
	logic               busy_q;
	logic               done_q;

	always_comb begin
		for (int i = 0; i < BCD_W / 4; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bcd_q <= '0;
			bin_q <= value;
		end else if (busy_q) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

FILE: hdl/unsigned_field_formatter.sv
// ----------------------------------------------------------------------------
// unsigned_field_formatter
// Formats a 16-bit value as a decimal, octal, hex or character field with
// left padding, one ASCII character per output word.
// ----------------------------------------------------------------------------
// Sequence: a decimal word first passes through the serial BCD unit, then
// every kind drops its suppressed leading zeros, then emits its pad and digit
// characters one per output word. Octal, hex and character skip the
// conversion. Words are taken one at a time: a new word is accepted only once
// the last character of the previous word has been issued.
// Reset clears the sequencer and the output valid flag; data is not reset.
module unsigned_field_formatter (
	input  logic clk,
	input  logic arst_n,
	uff_in_if.sink    din,
	uff_out_if.source dout
);
	import uff_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [DIG_W-1:0]  dig_q;
	logic [NDIG_W-1:0] ndig_q;
	logic [FW_W-1:0]   width_q;
	logic [FW_W-1:0]   padcnt_q;
	logic              zero_pad_q;
	logic              is_char_q;
	logic [CHAR_W-1:0] char_q;
	logic              ovalid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              last_q;

	logic              accept;
	logic              advance;
	logic              bcd_done;
	logic [BCD_W-1:0]  bcd;
	logic [FW_W-1:0]   ndig_ext;
	logic [CHAR_W-1:0] next_char;
	logic              next_last;

	uff_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && din.op == OP_DEC),
		.value  (din.value),
		.done   (bcd_done),
		.bcd    (bcd)
	);

	assign din.ready = (state_q == ST_IDLE);
	assign accept    = din.valid && din.ready;
	assign advance   = (state_q == ST_EMIT) && (!ovalid_q || dout.ready);
	assign ndig_ext  = {1'b0, ndig_q};

	always_comb begin
		if (padcnt_q != '0) begin
			next_char = zero_pad_q ? CH_ZERO : CH_SPACE;
			next_last = 1'b0;
		end else begin
			next_char = is_char_q ? char_q : ascii_digit(dig_q[DIG_W-1 -: 4]);
			next_last = (ndig_q == 3'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (advance) begin
				ovalid_q <= 1'b1;
			end else if (dout.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (din.op == OP_DEC) ? ST_CONV : ST_SKIP;
					end
				end
				ST_CONV: begin
					if (bcd_done) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (!(ndig_q > 3'd1 && dig_q[DIG_W-1 -: 4] == 4'd0)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (advance && next_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			width_q    <= (din.field_width > MAX_CHARS) ? MAX_CHARS : din.field_width;
			zero_pad_q <= din.zero_pad;
			is_char_q  <= (din.op == OP_CHAR);
			char_q     <= din.value[CHAR_W-1:0];
			unique case (din.op)
				OP_OCT: begin
					dig_q  <= {3'b0, din.value[15], 1'b0, din.value[14:12],
						1'b0, din.value[11:9], 1'b0, din.value[8:6],
						1'b0, din.value[5:3], 1'b0, din.value[2:0]};
					ndig_q <= 3'd6;
				end
				OP_HEX: begin
					dig_q  <= {din.value, 8'h00};
					ndig_q <= 3'd4;
				end
				OP_CHAR: begin
					dig_q  <= '0;
					ndig_q <= 3'd1;
				end
				default: begin
					dig_q  <= '0;
					ndig_q <= 3'd5;
				end
			endcase
		end else if (state_q == ST_CONV && bcd_done) begin
			dig_q <= {bcd, 4'h0};
		end else if (state_q == ST_SKIP) begin
			if (ndig_q > 3'd1 && dig_q[DIG_W-1 -: 4] == 4'd0) begin
				dig_q  <= {dig_q[DIG_W-5:0], 4'h0};
				ndig_q <= ndig_q - 3'd1;
			end else begin
				padcnt_q <= (width_q > ndig_ext) ? width_q - ndig_ext : '0;
			end
		end else if (advance) begin
			out_char_q <= next_char;
			last_q     <= next_last;
			if (padcnt_q != '0) begin
				padcnt_q <= padcnt_q - 4'd1;
			end else begin
				dig_q  <= {dig_q[DIG_W-5:0], 4'h0};
				ndig_q <= ndig_q - 3'd1;
			end
		end
	end

	assign dout.valid    = ovalid_q;
	assign dout.out_char = out_char_q;
	assign dout.last     = last_q;

endmodule
